/* rtl/nxp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nxp_pkg
// Types, constants and the microprogram of the next-permutation generator.
// ----------------------------------------------------------------------------
package nxp_pkg;

    // Largest permutation and field widths
    localparam int MAX_N  = 8;
    localparam int VAL_W  = 4;
    localparam int IDX_W  = 3;
    localparam int SIZE_W = 4;
    localparam int STEP_W = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd5;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // Microprogram addresses
    localparam step_t S_IDLE   = 5'd0;
    localparam step_t S_DISP   = 5'd1;
    localparam step_t S_JINIT  = 5'd2;
    localparam step_t S_JSCAN  = 5'd3;
    localparam step_t S_JCHK   = 5'd4;
    localparam step_t S_FIN    = 5'd5;
    localparam step_t S_KINIT  = 5'd6;
    localparam step_t S_KSCAN  = 5'd7;
    localparam step_t S_KDEC   = 5'd8;
    localparam step_t S_SWAP1  = 5'd9;
    localparam step_t S_SWAP2  = 5'd10;
    localparam step_t S_RINIT  = 5'd11;
    localparam step_t S_RCHK   = 5'd12;
    localparam step_t S_R1     = 5'd13;
    localparam step_t S_R2     = 5'd14;
    localparam step_t S_R3     = 5'd15;
    localparam step_t S_EINIT  = 5'd16;
    localparam step_t S_EMIT   = 5'd17;
    localparam step_t S_EDONE  = 5'd18;
    localparam step_t S_EXH    = 5'd19;
    localparam step_t S_LOADID = 5'd20;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_ID,
        OP_SET_FIN,
        OP_J_INIT,
        OP_J_SCAN,
        OP_K_INIT,
        OP_K_READ,
        OP_K_DEC,
        OP_WR_J_B,
        OP_WR_K_A,
        OP_R_INIT,
        OP_R_RD_LO,
        OP_R_SWAP_HI,
        OP_R_WR_LO,
        OP_E_INIT,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NEW,
        C_FINISHED,
        C_N_LT2,
        C_ASCENT,
        C_J_NZ,
        C_GREATER,
        C_NOT_LO_LT_HI,
        C_NOT_LAST
    } cond_t;

    // Exhausted result rides on a plain step; the exh bit of the word marks it
    localparam op_t OP_EMIT_EXH = OP_NOP;

    typedef struct packed {
        op_t   op;
        logic  exh;
        cond_t cond;
        step_t target;
        logic  wait_in;
        logic  wait_out;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic exh;
        logic exec;
        logic idle;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic new_req;
        logic finished;
        logic n_lt2;
        logic ascent;
        logic j_nz;
        logic greater;
        logic lo_lt_hi;
        logic e_last;
    } stat_t;

    function automatic uword_t uw(op_t op, logic exh, cond_t cond, step_t target,
                                  logic wait_in, logic wait_out);
        uword_t w;
        w.op       = op;
        w.exh      = exh;
        w.cond     = cond;
        w.target   = target;
        w.wait_in  = wait_in;
        w.wait_out = wait_out;
        return w;
    endfunction

    // Control store
    function automatic uword_t micro_rom(step_t s);
        uword_t w;
        case (s)
            S_IDLE:   w = uw(OP_NOP,       1'b0, C_NEW,          S_LOADID, 1'b1, 1'b0);
            S_DISP:   w = uw(OP_NOP,       1'b0, C_FINISHED,     S_EXH,    1'b0, 1'b0);
            S_JINIT:  w = uw(OP_J_INIT,    1'b0, C_N_LT2,        S_FIN,    1'b0, 1'b0);
            S_JSCAN:  w = uw(OP_J_SCAN,    1'b0, C_ASCENT,       S_KINIT,  1'b0, 1'b0);
            S_JCHK:   w = uw(OP_NOP,       1'b0, C_J_NZ,         S_JSCAN,  1'b0, 1'b0);
            S_FIN:    w = uw(OP_SET_FIN,   1'b0, C_ALWAYS,       S_EXH,    1'b0, 1'b0);
            S_KINIT:  w = uw(OP_K_INIT,    1'b0, C_NONE,         S_IDLE,   1'b0, 1'b0);
            S_KSCAN:  w = uw(OP_K_READ,    1'b0, C_GREATER,      S_SWAP1,  1'b0, 1'b0);
            S_KDEC:   w = uw(OP_K_DEC,     1'b0, C_ALWAYS,       S_KSCAN,  1'b0, 1'b0);
            S_SWAP1:  w = uw(OP_WR_J_B,    1'b0, C_NONE,         S_IDLE,   1'b0, 1'b0);
            S_SWAP2:  w = uw(OP_WR_K_A,    1'b0, C_NONE,         S_IDLE,   1'b0, 1'b0);
            S_RINIT:  w = uw(OP_R_INIT,    1'b0, C_NONE,         S_IDLE,   1'b0, 1'b0);
            S_RCHK:   w = uw(OP_NOP,       1'b0, C_NOT_LO_LT_HI, S_EINIT,  1'b0, 1'b0);
            S_R1:     w = uw(OP_R_RD_LO,   1'b0, C_NONE,         S_IDLE,   1'b0, 1'b0);
            S_R2:     w = uw(OP_R_SWAP_HI, 1'b0, C_NONE,         S_IDLE,   1'b0, 1'b0);
            S_R3:     w = uw(OP_R_WR_LO,   1'b0, C_ALWAYS,       S_RCHK,   1'b0, 1'b0);
            S_EINIT:  w = uw(OP_E_INIT,    1'b0, C_NONE,         S_IDLE,   1'b0, 1'b0);
            S_EMIT:   w = uw(OP_EMIT,      1'b0, C_NOT_LAST,     S_EMIT,   1'b0, 1'b1);
            S_EDONE:  w = uw(OP_NOP,       1'b0, C_ALWAYS,       S_IDLE,   1'b0, 1'b0);
            S_EXH:    w = uw(OP_EMIT_EXH,  1'b1, C_ALWAYS,       S_IDLE,   1'b0, 1'b1);
            S_LOADID: w = uw(OP_LOAD_ID,   1'b0, C_ALWAYS,       S_EINIT,  1'b0, 1'b0);
            default:  w = uw(OP_NOP,       1'b0, C_ALWAYS,       S_IDLE,   1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/nxp_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nxp_sequencer
// Step counter over the control store, with conditional jumps and stalls on
// the input and output handshakes.
// ----------------------------------------------------------------------------
module nxp_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire nxp_pkg::stat_t st,
    output nxp_pkg::ctrl_t      ctrl
);
    import nxp_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   stall;
    logic   take;

    // Fetch the control word of the current step
    assign word  = micro_rom(step_reg);
    assign stall = (word.wait_in && !st.in_fire) || (word.wait_out && !st.out_free);

    // Evaluate the jump condition
    always_comb
    begin
        case (word.cond)
            C_NONE:         take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NEW:          take = st.new_req;
            C_FINISHED:     take = st.finished;
            C_N_LT2:        take = st.n_lt2;
            C_ASCENT:       take = st.ascent;
            C_J_NZ:         take = st.j_nz;
            C_GREATER:      take = st.greater;
            C_NOT_LO_LT_HI: take = !st.lo_lt_hi;
            C_NOT_LAST:     take = !st.e_last;
            default:        take = 1'b0;
        endcase
    end

    // Hold, jump or advance
    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Drive the datapath
    always_comb
    begin
        ctrl.op   = word.op;
        ctrl.exh  = word.exh;
        ctrl.exec = !stall;
        ctrl.idle = (step_reg == S_IDLE);
    end

endmodule
`default_nettype wire

/* rtl/next_permutation_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_permutation_generator
// Emits the permutations of 1..n in lexicographic order, one per request,
// element by element, under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
// Flow: a restart request loads the identity and then emits it; a request
//   that finds the sequence already exhausted emits the exhausted result.
// Throughput: a new request is taken only in idle, after the last element of
//   the previous one; the element file has one read port and the microprogram
//   visits one element per step, emitting one per cycle unless stalled.
// Reset: perm_size 5, identity loaded, next request emits the identity.
// ----------------------------------------------------------------------------
module next_permutation_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        restart,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [nxp_pkg::VAL_W-1:0]        elem_value,
    output logic [nxp_pkg::IDX_W-1:0]        elem_index,
    output logic                             last_elem,
    output logic                             exhausted,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [nxp_pkg::SIZE_W-1:0]  perm_size
);
    import nxp_pkg::*;

    ctrl_t              ctrl;
    stat_t              st;
    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  n_eff;
    idx_t               nm1;
    val_t               perm_reg [MAX_N];
    idx_t               rd_addr;
    val_t               rd_val;
    val_t               a_reg;
    val_t               b_reg;
    idx_t               j_reg;
    idx_t               k_reg;
    idx_t               lo_reg;
    idx_t               hi_reg;
    idx_t               e_reg;
    logic               started_reg;
    logic               finished_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               cfg_fire;
    logic               emit_fire;
    logic               load_id;

    nxp_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl)
    );

    // Handshakes: configuration wins over a request in the same cycle
    assign cfg_ready = ctrl.idle;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = ctrl.idle && !cfg_valid;
    assign emit_fire = ctrl.exec && (ctrl.op == OP_EMIT || ctrl.exh);
    assign load_id   = cfg_fire || (ctrl.exec && ctrl.op == OP_LOAD_ID);

    // Clamp the size to 1..MAX_N
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(MAX_N))
        begin
            n_eff = SIZE_W'(MAX_N);
        end
        else
        begin
            n_eff = size_reg;
        end
    end
    assign nm1 = IDX_W'(n_eff - 1'b1);

    // Select the single read address of the element file
    always_comb
    begin
        case (ctrl.op)
            OP_J_INIT:    rd_addr = nm1;
            OP_J_SCAN:    rd_addr = j_reg - 1'b1;
            OP_K_READ:    rd_addr = k_reg;
            OP_R_RD_LO:   rd_addr = lo_reg;
            OP_R_SWAP_HI: rd_addr = hi_reg;
            OP_EMIT:      rd_addr = e_reg;
            default:      rd_addr = '0;
        endcase
    end
    assign rd_val = perm_reg[rd_addr];

    // Report conditions to the sequencer
    always_comb
    begin
        st.in_fire  = in_valid && in_ready;
        st.out_free = !out_valid_reg || out_ready;
        st.new_req  = restart || !started_reg;
        st.finished = finished_reg;
        st.n_lt2    = (n_eff < SIZE_W'(2));
        st.ascent   = (rd_val < a_reg);
        st.j_nz     = (j_reg != '0);
        st.greater  = (rd_val > a_reg);
        st.lo_lt_hi = (lo_reg < hi_reg);
        st.e_last   = (e_reg == nm1);
    end

    // Element file: identity load, swap writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_N; i++)
            begin
                perm_reg[i] <= VAL_W'(i + 1);
            end
        end
        else if (load_id)
        begin
            for (int i = 0; i < MAX_N; i++)
            begin
                perm_reg[i] <= VAL_W'(i + 1);
            end
        end
        else if (ctrl.exec)
        begin
            case (ctrl.op)
                OP_WR_J_B:    perm_reg[j_reg]  <= b_reg;
                OP_WR_K_A:    perm_reg[k_reg]  <= a_reg;
                OP_R_SWAP_HI: perm_reg[hi_reg] <= a_reg;
                OP_R_WR_LO:   perm_reg[lo_reg] <= b_reg;
                default:      ;
            endcase
        end
    end

    // Working registers of the scan, reverse and emit loops
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            case (ctrl.op)
                OP_J_INIT:
                begin
                    j_reg <= nm1;
                    a_reg <= rd_val;
                end
                OP_J_SCAN:
                begin
                    j_reg <= j_reg - 1'b1;
                    a_reg <= rd_val;
                end
                OP_K_INIT:    k_reg <= nm1;
                OP_K_READ:    b_reg <= rd_val;
                OP_K_DEC:     k_reg <= k_reg - 1'b1;
                OP_R_INIT:
                begin
                    lo_reg <= j_reg + 1'b1;
                    hi_reg <= nm1;
                end
                OP_R_RD_LO:   a_reg <= rd_val;
                OP_R_SWAP_HI: b_reg <= rd_val;
                OP_R_WR_LO:
                begin
                    lo_reg <= lo_reg + 1'b1;
                    hi_reg <= hi_reg - 1'b1;
                end
                OP_E_INIT:    e_reg <= '0;
                OP_EMIT:      e_reg <= e_reg + 1'b1;
                default:      ;
            endcase
        end
    end

    // Size register and run flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SIZE_RESET;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            size_reg     <= perm_size;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (ctrl.exec && ctrl.op == OP_LOAD_ID)
        begin
            started_reg  <= 1'b1;
            finished_reg <= 1'b0;
        end
        else if (ctrl.exec && ctrl.op == OP_SET_FIN)
        begin
            finished_reg <= 1'b1;
        end
    end

    // Output register: load on emit, drop when taken
    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            if (ctrl.exh)
            begin
                elem_value <= '0;
                elem_index <= '0;
                last_elem  <= 1'b1;
                exhausted  <= 1'b1;
            end
            else
            begin
                elem_value <= rd_val;
                elem_index <= e_reg;
                last_elem  <= st.e_last;
                exhausted  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* rtl/nxp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nxp_checker
// Port-level checks of the next-permutation generator, bound to the top level.
// ----------------------------------------------------------------------------
module nxp_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [nxp_pkg::VAL_W-1:0]   elem_value,
    input  wire logic [nxp_pkg::IDX_W-1:0]   elem_index,
    input  wire logic                        last_elem,
    input  wire logic                        exhausted,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready
);
    import nxp_pkg::*;

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(elem_value)
            && $stable(elem_index) && $stable(last_elem) && $stable(exhausted))
    else $error("stalled result changed");

    // Exhausted result is a single closing zero item
    a_exh_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> last_elem && elem_value == '0 && elem_index == '0)
    else $error("malformed exhausted result");

    // No new request while a permutation is still being emitted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_elem |-> !in_ready)
    else $error("request taken mid permutation");

    // Elements follow one another without gaps
    a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_elem |=>
            out_valid && elem_index == $past(elem_index) + 3'd1)
    else $error("element sequence broken");

    // Never take a request and a size write at the same edge
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !(cfg_valid && cfg_ready))
    else $error("request and size write taken together");

endmodule

bind next_permutation_generator nxp_checker u_nxp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .elem_value (elem_value),
    .elem_index (elem_index),
    .last_elem  (last_elem),
    .exhausted  (exhausted),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
`default_nettype wire
